// ===== hw/rtl/mtast_pkg.sv =====
// ----------------------------------------------------------------------------
// mtast_pkg: shared types and constants of the multi-turn angle tracker
// Sequencer states, register indexes, datapath widths and the control
// structs that pass between the sequencer, the divider and the window.
// ----------------------------------------------------------------------------
package mtast_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int ELAPSED_W = 16;
    localparam int TURNS_W   = 16;
    localparam int ANGLE_W   = 26;
    localparam int SPD_W     = 32;
    localparam int CPT_SHIFT = 10;

    localparam int DELTA_W = ANGLE_W + 1;
    localparam int GAIN_W  = 32;
    localparam int LIM_W   = 31;
    localparam int PROD_W  = DELTA_W + GAIN_W + 1;

    localparam int DVD_W = 58;
    localparam int DVR_W = ELAPSED_W;
    localparam int CNT_W = 6;

    localparam int IN_W  = 32;
    localparam int OUT_W = 80;
    localparam int CFG_W = 32;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_SPEED_GAIN     = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_LIMIT    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_DEADBAND = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = 32'd65536;
    localparam logic [LIM_W-1:0]  LIMIT_RESET    = 31'd1966080;
    localparam logic [LIM_W-1:0]  DEADBAND_RESET = 31'd6554;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_DELTA,
        ST_MULT,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_SCLAMP,
        ST_PUSH,
        ST_ADIV_GO,
        ST_ADIV_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic rd;
        logic push;
    } win_ctl_t;

endpackage

// ===== hw/rtl/mtast_div.sv =====
// ----------------------------------------------------------------------------
// mtast_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle. The dividend comes in aligned
// to the top bit; after the requested number of steps the quotient sits in
// the low bits of the shift register and holds until the next start.
// ----------------------------------------------------------------------------
module mtast_div
    import mtast_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] rem_next;
    logic [DVR_W-1:0] dvr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVR_W:0]   shifted;
    logic [DVR_W:0]   trial;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = shifted >= {1'b0, dvr_reg};
        trial    = shifted - {1'b0, dvr_reg};
        rem_next = ge ? trial[DVR_W-1:0] : shifted[DVR_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ===== hw/rtl/mtast_window.sv =====
// ----------------------------------------------------------------------------
// mtast_window: moving-average window
// Ring of the last accepted speeds with a running sum, a fill count and a
// write pointer. The entry under the pointer is read in the step before a push
// so that its value can leave the sum once the ring is full.
// ----------------------------------------------------------------------------
module mtast_window
    import mtast_pkg::*;
#(
    parameter int AVG_DEPTH = 8,
    parameter int SUM_W     = SPD_W + $clog2(AVG_DEPTH),
    parameter int FILL_W    = $clog2(AVG_DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  win_ctl_t                ctl,
    input  logic signed [SPD_W-1:0] spd,
    output logic signed [SUM_W-1:0] sum,
    output logic [FILL_W-1:0]       fill
);

    localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    logic signed [SPD_W-1:0] mem [AVG_DEPTH];
    logic signed [SPD_W-1:0] old_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;
    logic                    full;

    always_comb
    begin
        full      = fill_reg == FILL_W'(AVG_DEPTH);
        sum_next  = sum_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (ctl.push)
        begin
            if (full)
            begin
                sum_next = sum_reg + SUM_W'(spd) - SUM_W'(old_reg);
            end
            else
            begin
                sum_next  = sum_reg + SUM_W'(spd);
                fill_next = fill_reg + 1'b1;
            end
            ptr_next = (ptr_reg == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            old_reg <= mem[ptr_reg];
        end
        if (ctl.push)
        begin
            mem[ptr_reg] <= spd;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

// ===== hw/rtl/multi_turn_angle_speed_tracker.sv =====
// ----------------------------------------------------------------------------
// multi_turn_angle_speed_tracker: multi-turn angle and averaged speed
// Items are processed one at a time: the block accepts no new item until the
// result of the last one is loaded into the output register. The sequencer
// hands work to the one shared bit-serial divider: 58 steps for the speed
// quotient, then 32 + clog2(AVG_DEPTH) steps for the window average, skipped
// while no speed has yet entered the window. The sequencer itself does the turn
// count, angle, multiply, window update, divider hand-offs and output load. A
// stalled output holds the sequencer until the previous result is taken.
// A finished result waits in the output register while the next item is
// taken. Configuration writes are applied at once and belong to idle time.
// ----------------------------------------------------------------------------
module multi_turn_angle_speed_tracker
    import mtast_pkg::*;
#(
    parameter int AVG_DEPTH = 8,
    parameter int TURN_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // sample[9:0], elapsed_us[25:10]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // turns[15:0], total_angle[41:16], speed[73:42]
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int SUM_W  = SPD_W + $clog2(AVG_DEPTH);
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int AW     = (TURN_BITS + CPT_SHIFT + 1 > DELTA_W) ?
                            TURN_BITS + CPT_SHIFT + 1 : DELTA_W;

    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] ANGLE_MAX_W =
        {{(AW-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [AW-1:0] ANGLE_MIN_W =
        {{(AW-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};
    localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h7FFF_FFFF);
    localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h8000_0000);

    state_t state_reg;
    state_t state_next;

    logic [GAIN_W-1:0] gain_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [LIM_W-1:0]  deadband_reg;

    logic [2:0]                    lastq_reg;
    logic signed [TURN_BITS-1:0]   turn_reg;
    logic signed [TURN_BITS-1:0]   turn_next;
    logic [SAMPLE_W-1:0]           sample_reg;
    logic [ELAPSED_W-1:0]          elapsed_reg;
    logic signed [ANGLE_W-1:0]     total_reg;
    logic signed [ANGLE_W-1:0]     last_total_reg;
    logic signed [DELTA_W-1:0]     delta_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          spd_neg_reg;
    logic signed [SPD_W-1:0]       spd_reg;
    logic                          spd_ok_reg;
    logic                          avg_neg_reg;

    logic                          m_tvalid_reg;
    logic signed [TURNS_W-1:0]     out_turns_reg;
    logic signed [ANGLE_W-1:0]     out_total_reg;
    logic signed [SPD_W-1:0]       out_speed_reg;

    logic [SAMPLE_W-1:0]    in_sample;
    logic [ELAPSED_W-1:0]   in_elapsed;
    logic [2:0]             quad;
    logic                   accept;
    logic                   out_load;

    logic signed [AW-1:0]      turn_ext;
    logic signed [AW-1:0]      angle_wide;
    logic signed [ANGLE_W-1:0] angle_clamped;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  prod_mag;
    logic [DVD_W-1:0]          lim_sel;
    logic [SPD_W-1:0]          spd_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic [SPD_W-1:0]          avg_mag;
    logic signed [SPD_W-1:0]   speed_out;

    div_req_t               div_req;
    div_stat_t              div_stat;
    logic [DVD_W-1:0]       div_dividend;
    logic [DVR_W-1:0]       div_divisor;
    logic [DVD_W-1:0]       div_q;

    win_ctl_t                win_ctl;
    logic signed [SUM_W-1:0] win_sum;
    logic [FILL_W-1:0]       win_fill;

    mtast_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    mtast_window
    #(
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W),
        .FILL_W    (FILL_W)
    )
    u_window
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .spd   (spd_reg),
        .sum   (win_sum),
        .fill  (win_fill)
    );

    assign in_sample  = s_tdata[SAMPLE_W-1:0];
    assign in_elapsed = s_tdata[SAMPLE_W+ELAPSED_W-1:SAMPLE_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_ANGLE;
            ST_ANGLE:     state_next = ST_DELTA;
            ST_DELTA:     state_next = ST_MULT;
            ST_MULT:      state_next = ST_SDIV_GO;
            ST_SDIV_GO:   state_next = ST_SDIV_WAIT;
            ST_SDIV_WAIT: if (div_stat.done) state_next = ST_SCLAMP;
            ST_SCLAMP:    state_next = ST_PUSH;
            ST_PUSH:      state_next = ST_ADIV_GO;
            ST_ADIV_GO:   state_next = (win_fill != '0) ? ST_ADIV_WAIT : ST_FIN;
            ST_ADIV_WAIT: if (div_stat.done) state_next = ST_FIN;
            ST_FIN:       if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready      = 1'b0;
        div_req.start = 1'b0;
        div_req.iters = CNT_W'(DVD_W);
        div_dividend  = prod_mag[DVD_W-1:0];
        div_divisor   = elapsed_reg;
        win_ctl.rd    = 1'b0;
        win_ctl.push  = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_SDIV_GO: div_req.start = 1'b1;
            ST_SCLAMP:  win_ctl.rd = 1'b1;
            ST_PUSH:    win_ctl.push = spd_ok_reg;
            ST_ADIV_GO:
            begin
                div_req.start = win_fill != '0;
                div_req.iters = CNT_W'(SUM_W);
                div_dividend  = {sum_mag, {(DVD_W-SUM_W){1'b0}}};
                div_divisor   = DVR_W'(win_fill);
            end
            ST_FIN:     out_load = !m_tvalid_reg || m_tready;
            default:    s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // datapath
    always_comb
    begin
        quad      = {1'b0, in_sample[SAMPLE_W-1:SAMPLE_W-2]} + 3'd1;
        turn_next = turn_reg;
        if (quad == 3'd1 && lastq_reg == 3'd4 && turn_reg != TURN_MAX)
        begin
            turn_next = turn_reg + 1'b1;
        end
        else if (quad == 3'd4 && lastq_reg == 3'd1 && turn_reg != TURN_MIN)
        begin
            turn_next = turn_reg - 1'b1;
        end

        turn_ext   = AW'(turn_reg);
        angle_wide = (turn_ext <<< CPT_SHIFT) + $signed({{(AW-SAMPLE_W){1'b0}}, sample_reg});
        if (angle_wide > ANGLE_MAX_W)
        begin
            angle_clamped = ANGLE_MAX_W[ANGLE_W-1:0];
        end
        else if (angle_wide < ANGLE_MIN_W)
        begin
            angle_clamped = ANGLE_MIN_W[ANGLE_W-1:0];
        end
        else
        begin
            angle_clamped = angle_wide[ANGLE_W-1:0];
        end

        gain_s   = $signed({1'b0, gain_reg});
        prod_mag = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

        lim_sel = spd_neg_reg ? NEG_LIM : POS_LIM;
        spd_mag = (div_q > lim_sel) ? lim_sel[SPD_W-1:0] : div_q[SPD_W-1:0];

        sum_mag   = win_sum[SUM_W-1] ? -win_sum : win_sum;
        avg_mag   = div_q[SPD_W-1:0];
        speed_out = '0;
        if (win_fill != '0 && avg_mag > {1'b0, deadband_reg})
        begin
            speed_out = avg_neg_reg ? -avg_mag : avg_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gain_reg       <= GAIN_RESET;
            limit_reg      <= LIMIT_RESET;
            deadband_reg   <= DEADBAND_RESET;
            lastq_reg      <= '0;
            turn_reg       <= '0;
            last_total_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SPEED_GAIN:     gain_reg     <= cfg_wdata;
                    REG_SPEED_LIMIT:    limit_reg    <= cfg_wdata[LIM_W-1:0];
                    REG_SPEED_DEADBAND: deadband_reg <= cfg_wdata[LIM_W-1:0];
                    default:            gain_reg     <= gain_reg;
                endcase
            end
            if (accept)
            begin
                lastq_reg <= quad;
                turn_reg  <= turn_next;
            end
            if (state_reg == ST_DELTA)
            begin
                last_total_reg <= total_reg;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= in_sample;
            elapsed_reg <= (in_elapsed == '0) ? ELAPSED_W'(1) : in_elapsed;
        end
        if (state_reg == ST_ANGLE)
        begin
            total_reg <= angle_clamped;
        end
        if (state_reg == ST_DELTA)
        begin
            delta_reg <= DELTA_W'(total_reg) - DELTA_W'(last_total_reg);
        end
        if (state_reg == ST_MULT)
        begin
            prod_reg <= delta_reg * gain_s;
        end
        if (state_reg == ST_SDIV_GO)
        begin
            spd_neg_reg <= prod_reg[PROD_W-1];
        end
        if (state_reg == ST_SCLAMP)
        begin
            spd_reg    <= spd_neg_reg ? -spd_mag : spd_mag;
            spd_ok_reg <= spd_mag < {1'b0, limit_reg};
        end
        if (state_reg == ST_ADIV_GO)
        begin
            avg_neg_reg <= win_sum[SUM_W-1];
        end
        if (out_load)
        begin
            out_turns_reg <= TURNS_W'(turn_reg);
            out_total_reg <= total_reg;
            out_speed_reg <= speed_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-TURNS_W-ANGLE_W-SPD_W){1'b0}},
                       out_speed_reg, out_total_reg, out_turns_reg};

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_fill <= FILL_W'(AVG_DEPTH))
        else $error("window fill above depth");

    a_turn_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(turn_reg) |-> $past(s_tvalid && s_tready))
        else $error("turn count moved without an item");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_tvalid && !m_tready) |=> state_reg == ST_FIN)
        else $error("result dropped while output stalled");
`endif

endmodule
